// ===== sv/rgbe_pkg.sv =====
package rgbe_pkg;

  localparam int unsigned ChanW = 32;
  localparam int unsigned MantW = 9;
  localparam int unsigned ExpW  = 5;

  localparam logic [31:0] ChMaxBits = 32'h477F_8000;
  localparam logic [31:0] ChMinBits = 32'h3780_0000;
  localparam logic [31:0] ExpAdd    = 32'h0780_4000;
  localparam logic [31:0] ExpMask   = 32'h7F80_0000;

  // Clamp one channel to [0, 65408]; negatives and NaN go to zero.
  function automatic logic [31:0] clamp_channel(input logic [31:0] x);
    logic [31:0] r;
    if (x[31]) begin
      r = '0;
    end else if (x > ExpMask) begin
      r = '0;
    end else if (x > ChMaxBits) begin
      r = ChMaxBits;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

// ===== sv/rgbe_align.sv =====
// Align one clamped channel to the shared exponent, round to nearest even.
// Stage A: compute shift and split. Stage B: round.
module rgbe_align (
  input  logic                  clk,
  input  logic                  en_a,
  input  logic                  en_b,
  input  logic [31:0]           x,
  input  logic [7:0]            ee,
  output logic [rgbe_pkg::MantW-1:0] mant
);
  import rgbe_pkg::*;

  logic [7:0]  ev;
  logic [23:0] m;
  logic [8:0]  s;
  logic [23:0] q_c;
  logic        rnd_c;
  logic [47:0] wide;
  logic [9:0]  q;
  logic        rnd;

  always_comb begin
    ev = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    m  = {(x[30:23] != 8'd0), x[22:0]};
    s  = {1'b0, ee} - {1'b0, ev};
    // Shift mantissa so the kept bits land in [47:24] and fraction below.
    wide  = (s[8] || s > 9'd47) ? 48'd0 : ({m, 24'd0} >> s[5:0]);
    q_c   = wide[47:24];
    // Round up when fraction above half, or exactly half and q odd.
    rnd_c = wide[23] && ((wide[22:0] != 23'd0) || wide[24]);
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      q   <= q_c[9:0];
      rnd <= rnd_c;
    end
    if (en_b) begin
      mant <= q[MantW-1:0] + {{(MantW-1){1'b0}}, rnd};
    end
  end

endmodule

// ===== sv/rgb_float_to_shared_exponent_pack.sv =====
// RGB9E5 encoder: three IEEE single channels in, one 32-bit shared-exponent
// word out (exponent [31:27], blue [26:18], green [17:9], red [8:0]). Channels
// are clamped to [0, 65408]; negatives and NaN encode as zero. The block is a
// four-stage pipeline (clamp, shared exponent, alignment split, rounding/pack)
// and takes one transaction per clock unless the output holds an untaken one.
// A stall on the master side holds every stage.
module rgb_float_to_shared_exponent_pack (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // red_bits, green_bits, blue_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // packed_word
);
  import rgbe_pkg::*;

  logic [3:0]  vld;
  logic        adv;
  logic [31:0] cr1, cg1, cb1;
  logic [31:0] cr2, cg2, cb2;
  logic [7:0]  ee2, ee3;
  logic [31:0] mx;
  logic [MantW-1:0] kr, kg, kb;

  // Advance the whole pipe unless the output holds an untaken transaction.
  assign adv      = !vld[3] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], s_tvalid};
    end
  end

  always_comb begin
    mx = ChMinBits;
    if (cr1 > mx) mx = cr1;
    if (cg1 > mx) mx = cg1;
    if (cb1 > mx) mx = cb1;
  end

  logic [31:0] ee_sum;
  assign ee_sum = (mx + ExpAdd) & ExpMask;

  always_ff @(posedge clk) begin
    if (adv) begin
      cr1 <= clamp_channel(s_tdata[31:0]);
      cg1 <= clamp_channel(s_tdata[63:32]);
      cb1 <= clamp_channel(s_tdata[95:64]);
      cr2 <= cr1;
      cg2 <= cg1;
      cb2 <= cb1;
      ee2 <= ee_sum[30:23];
      ee3 <= ee2;
    end
  end

  rgbe_align u_r (.clk, .en_a(adv), .en_b(adv), .x(cr2), .ee(ee2), .mant(kr));
  rgbe_align u_g (.clk, .en_a(adv), .en_b(adv), .x(cg2), .ee(ee2), .mant(kg));
  rgbe_align u_b (.clk, .en_a(adv), .en_b(adv), .x(cb2), .ee(ee2), .mant(kb));

  logic [7:0] ee4;
  always_ff @(posedge clk) begin
    if (adv) ee4 <= ee3;
  end

  logic [7:0] e_field;
  assign e_field = ee4 + 8'd2;
  assign m_tdata = {e_field[ExpW-1:0], kb, kg, kr};

endmodule

// ===== sv/rgbe_checker.sv =====
module rgbe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("stall");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("ready");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready ##1 m_tready [*3] |=> m_tvalid)
    else $error("latency");
endmodule

bind rgb_float_to_shared_exponent_pack rgbe_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata);

// ===== test/rgb_float_to_shared_exponent_pack_test.sv =====
module rgb_float_to_shared_exponent_pack_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbe_pkg::*;

  localparam int unsigned NumRandom = 700;

  // Channel values of interest, as IEEE single bit patterns
  localparam logic [31:0] PosZero  = 32'h0000_0000;
  localparam logic [31:0] NegZero  = 32'h8000_0000;
  localparam logic [31:0] PosInf   = 32'h7F80_0000;
  localparam logic [31:0] NegInf   = 32'hFF80_0000;
  localparam logic [31:0] QuietNan = 32'h7FC0_0000;
  localparam logic [31:0] NegNan   = 32'hFFC0_0001;
  localparam logic [31:0] OneF     = 32'h3F80_0000;
  localparam logic [31:0] NegOneF  = 32'hBF80_0000;
  localparam logic [31:0] SubMax   = 32'h007F_FFFF;
  localparam logic [31:0] AllOnes  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] blue;
    logic [31:0] green;
    logic [31:0] red;
  } pixel_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;   // red_bits, green_bits, blue_bits
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // packed_word

  pixel_t      pixel_queue[$];
  logic [31:0] word_queue[$];
  int          mismatches;
  bit          stim_done;
  bit          calm;        // no idling on either side while set
  int          hold_cycles; // receiver hold-off count for back-pressure
  logic        s_tready_seen;

  rgb_float_to_shared_exponent_pack DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Clamp to [0, 65408]; negatives and NaN go to zero.
  function automatic logic [31:0] limit_channel(logic [31:0] x);
    if (x[31] || x > 32'h7F80_0000) return '0;
    if (x > 32'h477F_8000) return 32'h477F_8000;
    return x;
  endfunction

  // Round channel to a multiple of 2^(align_exp-150), ties to even; keep 9 bits.
  function automatic logic [8:0] scale_mantissa(logic [31:0] x, logic [7:0] align_exp);
    logic [8:0]  ev;
    logic [63:0] sig;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] half;
    int          sh;
    ev  = {1'b0, x[30:23]};
    sig = {41'd0, x[22:0]};
    if (ev == 0) begin
      ev = 9'd1;
    end else begin
      sig[23] = 1'b1;
    end
    if (ev >= {1'b0, align_exp}) return '0;
    sh = int'(align_exp) - int'(ev);
    if (sh >= 40) return '0;
    quo  = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && quo[0])) quo = quo + 64'd1;
    return quo[8:0];
  endfunction

  function automatic logic [31:0] encode_rgb9e5(pixel_t p);
    logic [31:0] cr;
    logic [31:0] cg;
    logic [31:0] cb;
    logic [31:0] peak;
    logic [31:0] sum;
    logic [7:0]  ee;
    logic [4:0]  exp_field;
    cr = limit_channel(p.red);
    cg = limit_channel(p.green);
    cb = limit_channel(p.blue);
    peak = 32'h3780_0000;
    if (cr > peak) peak = cr;
    if (cg > peak) peak = cg;
    if (cb > peak) peak = cb;
    // Max exponent plus 15, with the half-up carry of the top nine bits
    sum = peak + 32'h0780_4000;
    ee  = sum[30:23];
    exp_field = 5'(ee + 8'd2);
    return {exp_field, scale_mantissa(cb, ee), scale_mantissa(cg, ee),
            scale_mantissa(cr, ee)};
  endfunction

  // Random channel: mostly in range, with some out-of-range and odd patterns
  function automatic logic [31:0] rand_channel();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = $urandom();
      1:       v = {1'b1, 31'($urandom())};
      2:       v = {1'b0, 8'($urandom_range(143, 255)), 23'($urandom())};
      3:       v = {1'b0, 8'd0, 23'($urandom())};
      4:       v = {1'b0, 8'($urandom_range(100, 115)), 23'($urandom())};
      5:       v = {1'b0, 8'd142, 23'($urandom_range(32'h7F_0000, 32'h7F_FFFF))};
      // Top nine bits all ones: exercises the rounding carry
      6:       v = {1'b0, 8'($urandom_range(104, 142)), 9'h1FF, 14'($urandom())};
      default: v = {1'b0, 8'($urandom_range(110, 142)), 23'($urandom())};
    endcase
    return v;
  endfunction

  function automatic pixel_t make_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
    pixel_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    return p;
  endfunction

  // Fill the stimulus queue: directed corner cases first, then random pixels.
  initial begin
    pixel_t p;
    calm = 1'b0;
    hold_cycles = 0;
    stim_done = 1'b0;
    pixel_queue.push_back(make_pixel(PosZero, PosZero, PosZero));
    pixel_queue.push_back(make_pixel(NegZero, NegInf, NegOneF));
    pixel_queue.push_back(make_pixel(QuietNan, NegNan, AllOnes));
    pixel_queue.push_back(make_pixel(PosInf, OneF, PosZero));
    pixel_queue.push_back(make_pixel(ChMaxBits, ChMaxBits, ChMaxBits));
    pixel_queue.push_back(make_pixel(32'h477F_8001, 32'h4780_0000, 32'h7F7F_FFFF));
    pixel_queue.push_back(make_pixel(SubMax, 32'h0000_0001, OneF));
    pixel_queue.push_back(make_pixel(SubMax, 32'h0000_0001, PosZero));
    pixel_queue.push_back(make_pixel(ChMinBits, 32'h3700_0000, 32'h3680_0000));
    pixel_queue.push_back(make_pixel(32'h377F_FFFF, PosZero, 32'h3300_0001));
    // Rounding carry into the next exponent
    pixel_queue.push_back(make_pixel(32'h3FFF_C000, 32'h3FFF_BFFF, 32'h3F00_0000));
    pixel_queue.push_back(make_pixel(32'h3F7F_C000, OneF, 32'h3B80_0000));
    // Ties: odd and even quotients at the half point
    pixel_queue.push_back(make_pixel(OneF, 32'h3B00_0000, 32'h3BC0_0000));
    pixel_queue.push_back(make_pixel(32'h7FFF_FFFF, 32'h0000_0000, 32'h4000_0000));
    pixel_queue.push_back(make_pixel(AllOnes, ChMinBits, 32'h3F2A_AAAB));
    for (int i = 0; i < NumRandom; i++) begin
      p.red   = rand_channel();
      p.green = rand_channel();
      p.blue  = rand_channel();
      pixel_queue.push_back(p);
    end
  end

  // Driver: present the next pixel at the falling edge, idle at random.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!s_tvalid || s_tready_seen) begin
      if (pixel_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 35)) begin
        s_tdata  <= pixel_queue.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Was the current item accepted at the last rising edge?
  always @(posedge clk) begin
    s_tready_seen <= s_tvalid && s_tready && !rst;
    if (!rst && s_tvalid && s_tready) word_queue.push_back(encode_rgb9e5(pixel_t'(s_tdata)));
  end

  // Receiver: random stalls, with a long hold-off while the sender keeps going.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || $urandom_range(0, 99) >= 35;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (word_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %08h", m_tdata);
      end else begin
        want = word_queue.pop_front();
        if (m_tdata !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("packed_word mismatch: expected %08h, actual %08h (e %0d/%0d)",
                     want, m_tdata, want[31:27], m_tdata[31:27]);
        end
      end
    end
  end

  // Sequence the run: reset, phases of idling, end of test.
  initial begin
    mismatches = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // Long hold-off early so the pipeline fills and stalls its input
    wait (word_queue.size() > 0);
    @(negedge clk);
    hold_cycles = 60;
    wait (pixel_queue.size() < 400);
    // Stretch with no idling on either side
    calm = 1'b1;
    wait (pixel_queue.size() < 250);
    calm = 1'b0;
    wait (pixel_queue.size() == 0 && !s_tvalid);
    wait (word_queue.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && word_queue.size() == 0) begin
      $display("rgb_float_to_shared_exponent_pack_test: done, clean");
    end else begin
      $display("rgb_float_to_shared_exponent_pack_test: done, errors");
    end
    $finish;
  end

  // Timeout
  initial begin
    #200us;
    $display("rgb_float_to_shared_exponent_pack_test: done, errors");
    $finish;
  end

endmodule
